[hw/rtl/rwph_pkg.sv]
// ============================================================================
// rwph_pkg: shared types and constants of the rolling polynomial hash
// Holds the modulus, the base, the Barrett reciprocal, the digit mapping and
// the command record that travels from the front end to the back end.
// ============================================================================
package rwph_pkg;

	localparam int BYTE_W = 8;
	localparam int HASH_W = 30;
	localparam int LEN_W  = 11;

	localparam logic [HASH_W-1:0] HASH_PRIME   = 30'd998244353;
	localparam logic [HASH_W-1:0] HASH_BASE    = 30'd31;
	localparam logic [HASH_W-1:0] DIGIT_OFFSET = 30'd96;

	// Barrett reciprocal floor(2^60 / prime); it fits in 31 bits.
	localparam logic [63:0] MU_WIDE    = 64'h1000_0000_0000_0000 / 64'd998244353;
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	// Depth of the command queue between front end and back end.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_FIRST = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_SLIDE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] new_byte;
		logic [BYTE_W-1:0] old_byte;
		logic              produce;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_OLD,
		BK_POW,
		BK_HASH,
		BK_SEND
	} back_state_t;

	// Digit of a byte: byte minus the offset, as a non-negative residue.
	function automatic logic [HASH_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] bw;
		bw = HASH_W'(b);
		if (bw >= DIGIT_OFFSET) begin
			digit_of = bw - DIGIT_OFFSET;
		end else begin
			digit_of = HASH_PRIME - DIGIT_OFFSET + bw;
		end
	endfunction

	// Modular subtraction of two residues.
	function automatic logic [HASH_W-1:0] sub_p(input logic [HASH_W-1:0] x,
			input logic [HASH_W-1:0] y);
		if (x >= y) begin
			sub_p = x - y;
		end else begin
			sub_p = x + (HASH_PRIME - y);
		end
	endfunction

endpackage

[hw/rtl/rolling_window_polynomial_hash.sv]
// ============================================================================
// rolling_window_polynomial_hash: Rabin-Karp rolling hash over a byte stream
// Keeps the base-31 polynomial hash, modulo 998244353, of the last
// window_length symbols and emits one hash per byte once the window is full.
// ============================================================================
// Each accepted byte beat maps to the digit (byte - 96) mod 998244353. While
// the window fills, the hash grows by Horner's rule and the power 31^(m-1) is
// built beside it; the byte that fills the window yields the first hash beat,
// and every later byte removes the oldest digit times that power, multiplies
// by 31 and adds the new digit, yielding one hash beat. A byte beat with
// start_of_string set clears the window before it is taken, and so does any
// write of window_length. A length of zero acts as 1, and one above MAX_WINDOW
// acts as MAX_WINDOW. In the arithmetic side the first byte of a string is
// loaded without a multiplication; every other byte makes two serial passes
// through the five-stage modular multiplier (power times 31, then hash times
// 31 while filling; oldest digit times power, then hash times 31 once full).
// A byte that yields a hash then passes through a send state. An input stage
// and a two-entry command queue sit in front of
// the arithmetic, so input beats are taken while the previous byte is still
// being worked on, and a finished hash waits in an output register without
// holding up the input. The window memory needs no clearing after reset.
module rolling_window_polynomial_hash #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  symbol_byte,
	input  logic        start_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] window_length
);
	import rwph_pkg::*;

	// Commands travel from the front end through the queue to the back end.
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	rwph_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.symbol_byte     (symbol_byte),
		.start_of_string (start_of_string),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.window_length   (window_length),
		.push            (push),
		.push_cmd        (push_cmd),
		.queue_full      (queue_full)
	);

	rwph_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// The back end needs no clearing on a length write: the next command
	// after any clear is always a first-symbol command that reloads its state.
	rwph_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule

[hw/rtl/rwph_front.sv]
// ============================================================================
// rwph_front: input side of the rolling hash
// Accepts byte beats, keeps the window memory and fill count, reads the byte
// that leaves the window and hands one command per byte to the queue.
// ============================================================================
module rwph_front #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 symbol_byte,
	input  logic                       start_of_string,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [10:0]                window_length,
	output logic                       push,
	output rwph_pkg::cmd_t             push_cmd,
	input  logic                       queue_full
);
	import rwph_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = (CW > LEN_W) ? CW : LEN_W;
	localparam int PW = CW + 1;

	logic [LEN_W-1:0]  len_q;
	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     fill_q;
	logic [BYTE_W-1:0] window_mem [0:MAX_WINDOW-1];
	logic [BYTE_W-1:0] old_byte_q;

	logic              valid_s1;
	cmd_kind_t         kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              produce_s1;

	logic              accept;
	logic [LW-1:0]     len_ext;
	logic [LW-1:0]     m_wide;
	logic [CW-1:0]     m_len;
	logic [CW-1:0]     fill_eff;
	logic [AW-1:0]     wp_eff;
	logic [PW-1:0]     back_sum;
	logic [AW-1:0]     rd_addr;
	cmd_kind_t         kind_new;
	logic              produce_new;

	assign cfg_ready = 1'b1;
	assign push      = valid_s1 && !queue_full;
	assign in_stall  = valid_s1 && !push;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		len_ext = LW'(len_q);
		if (len_ext == '0) begin
			m_wide = LW'(1);
		end else if (len_ext > LW'(MAX_WINDOW)) begin
			m_wide = LW'(MAX_WINDOW);
		end else begin
			m_wide = len_ext;
		end
		m_len = m_wide[CW-1:0];

		fill_eff = start_of_string ? '0 : fill_q;
		wp_eff   = start_of_string ? '0 : wp_q;

		// Slot of the oldest byte in a full window.
		if (PW'(wp_eff) >= PW'(m_len)) begin
			back_sum = PW'(wp_eff) - PW'(m_len);
		end else begin
			back_sum = PW'(wp_eff) + PW'(MAX_WINDOW) - PW'(m_len);
		end
		rd_addr = back_sum[AW-1:0];

		if (fill_eff == '0) begin
			kind_new    = CMD_FIRST;
			produce_new = (m_len == CW'(1));
		end else if (fill_eff < m_len) begin
			kind_new    = CMD_FILL;
			produce_new = ((fill_eff + CW'(1)) == m_len);
		end else begin
			kind_new    = CMD_SLIDE;
			produce_new = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(1);
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			len_q  <= window_length;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= (fill_eff < m_len) ? fill_eff + CW'(1) : fill_eff;
			wp_q   <= (wp_eff == AW'(MAX_WINDOW - 1)) ? '0 : wp_eff + AW'(1);
		end
	end

	// Read-first: a full window of maximum length reads the slot it overwrites.
	always_ff @(posedge clk) begin
		if (accept) begin
			old_byte_q          <= window_mem[rd_addr];
			window_mem[wp_eff]  <= symbol_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_new;
			byte_s1    <= symbol_byte;
			produce_s1 <= produce_new;
		end
	end

	always_comb begin
		push_cmd.kind     = kind_s1;
		push_cmd.new_byte = byte_s1;
		push_cmd.old_byte = old_byte_q;
		push_cmd.produce  = produce_s1;
	end

endmodule

[hw/rtl/rwph_queue.sv]
// ============================================================================
// rwph_queue: command queue between front end and back end
// A small first-in first-out buffer of command records.
// ============================================================================
module rwph_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rwph_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           head_valid,
	output rwph_pkg::cmd_t head_cmd,
	input  logic           pop
);
	import rwph_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slots_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/rwph_modmul.sv]
// ============================================================================
// rwph_modmul: five-stage modular multiply-add
// Computes (a * b + c) mod prime with Barrett reduction, one register after
// each multiplication.
// ============================================================================
module rwph_modmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] op_a,
	input  logic [29:0] op_b,
	input  logic [29:0] op_c,
	output logic        done,
	output logic [29:0] result
);
	import rwph_pkg::*;

	logic [HASH_W-1:0] a_s1, b_s1, c_s1;
	logic [59:0]       x_s2;
	logic [61:0]       q2_s3;
	logic [31:0]       x_s3;
	logic [31:0]       q3p_s4;
	logic [31:0]       x_s4;
	logic [HASH_W-1:0] r_s5;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0]       r_raw;
	logic [31:0]       r_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// The Barrett remainder stays below three times the prime.
	always_comb begin
		r_raw = x_s4 - q3p_s4;
		if (r_raw >= (32'(HASH_PRIME) << 1)) begin
			r_fix = r_raw - (32'(HASH_PRIME) << 1);
		end else if (r_raw >= 32'(HASH_PRIME)) begin
			r_fix = r_raw - 32'(HASH_PRIME);
		end else begin
			r_fix = r_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_s1 <= op_a;
			b_s1 <= op_b;
			c_s1 <= op_c;
		end
		x_s2   <= 60'(a_s1) * 60'(b_s1) + 60'(c_s1);
		q2_s3  <= 62'(x_s2[59:29]) * 62'(BARRETT_MU);
		x_s3   <= x_s2[31:0];
		q3p_s4 <= 32'(q2_s3[61:31]) * 32'(HASH_PRIME);
		x_s4   <= x_s3;
		r_s5   <= r_fix[HASH_W-1:0];
	end

	assign done   = v_s5;
	assign result = r_s5;

endmodule

[hw/rtl/rwph_back.sv]
// ============================================================================
// rwph_back: arithmetic side of the rolling hash
// Takes one command at a time, updates the running hash and the top power
// through the shared modular multiplier and registers each result beat.
// ============================================================================
module rwph_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rwph_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [29:0]    hash_value
);
	import rwph_pkg::*;

	back_state_t       state_q, state_next;
	cmd_t              cur_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] power_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;

	logic              mm_start;
	logic [HASH_W-1:0] mm_a, mm_b, mm_c;
	logic              mm_done;
	logic [HASH_W-1:0] mm_result;
	logic              out_free;
	logic              load_out;

	rwph_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.op_a   (mm_a),
		.op_b   (mm_b),
		.op_c   (mm_c),
		.done   (mm_done),
		.result (mm_result)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		mm_start   = 1'b0;
		mm_a       = hash_q;
		mm_b       = HASH_BASE;
		mm_c       = '0;
		load_out   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					case (head_cmd.kind)
						CMD_FIRST: begin
							state_next = head_cmd.produce ? BK_SEND : BK_IDLE;
						end
						CMD_FILL: begin
							mm_start   = 1'b1;
							mm_a       = power_q;
							state_next = BK_POW;
						end
						CMD_SLIDE: begin
							mm_start   = 1'b1;
							mm_a       = digit_of(head_cmd.old_byte);
							mm_b       = power_q;
							state_next = BK_OLD;
						end
						default: begin
							state_next = BK_IDLE;
						end
					endcase
				end
			end
			BK_OLD: begin
				if (mm_done) begin
					mm_start   = 1'b1;
					mm_a       = sub_p(hash_q, mm_result);
					mm_c       = digit_of(cur_q.new_byte);
					state_next = BK_HASH;
				end
			end
			BK_POW: begin
				if (mm_done) begin
					mm_start   = 1'b1;
					mm_c       = digit_of(cur_q.new_byte);
					state_next = BK_HASH;
				end
			end
			BK_HASH: begin
				if (mm_done) begin
					state_next = cur_q.produce ? BK_SEND : BK_IDLE;
				end
			end
			BK_SEND: begin
				if (out_free) begin
					load_out   = 1'b1;
					state_next = BK_IDLE;
				end
			end
			default: begin
				state_next = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_cmd;
			if (head_cmd.kind == CMD_FIRST) begin
				hash_q  <= digit_of(head_cmd.new_byte);
				power_q <= HASH_W'(1);
			end
		end
		if (state_q == BK_POW && mm_done) begin
			power_q <= mm_result;
		end
		if (state_q == BK_HASH && mm_done) begin
			hash_q <= mm_result;
		end
		if (load_out) begin
			out_hash_q <= hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = out_hash_q;

endmodule

[tb/tb_rolling_window_polynomial_hash.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_rolling_window_polynomial_hash: self-checking bench of the rolling hash
// Streams byte beats through the block under several window lengths and
// checks every hash beat against a behavioral predictor kept in this file.
// ============================================================================
// The run opens with a short table of directed rows: single-symbol windows
// whose hash is simply the digit of the byte, the digit extremes, a zero
// length, start flags in the middle of a string, and slides over bytes below
// the digit offset. Random phases follow. Each phase writes a new length and
// then streams mostly lowercase text, with some raw bytes and a few start
// flags mixed in. One long phase fills the largest window through a clamped
// length, so that the power 31^(m-1) reaches its deepest value. Both sides
// idle at random, except for one quiet stretch in which beats go back to back.
module tb_rolling_window_polynomial_hash;
	import rwph_pkg::HASH_PRIME;
	import rwph_pkg::HASH_BASE;
	import rwph_pkg::DIGIT_OFFSET;

	localparam int WINDOW_DEPTH = 1024;
	localparam int IDLE_PCT = 21;
	// Several bytes may still sit in the input stage and the command queue,
	// each still to be worked through in the arithmetic side.
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_BEATS = 200;
	localparam int MAX_REPORTS = 20;

	typedef enum logic {
		ROW_BYTE,
		ROW_LENGTH
	} row_kind_t;

	// A byte row carries the byte in the low bits of value; a length row
	// carries the new window length. The hash column is meaningful only
	// where typed is set.
	typedef struct packed {
		row_kind_t   kind;
		logic [10:0] value;
		logic        sof;
		logic        typed;
		logic [29:0] hash;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// After reset the window holds one symbol, so each hash is the digit.
		'{ROW_BYTE,   11'd96,   1'b0, 1'b1, 30'd0},
		'{ROW_BYTE,   11'd97,   1'b0, 1'b1, 30'd1},
		'{ROW_BYTE,   11'd255,  1'b0, 1'b1, 30'd159},
		'{ROW_BYTE,   11'd0,    1'b0, 1'b1, 30'd998244257},
		'{ROW_BYTE,   11'd95,   1'b0, 1'b1, 30'd998244352},
		'{ROW_BYTE,   11'd128,  1'b1, 1'b1, 30'd32},
		// A zero length behaves as a one-symbol window.
		'{ROW_LENGTH, 11'd0,    1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd122,  1'b0, 1'b1, 30'd26},
		'{ROW_BYTE,   11'd96,   1'b1, 1'b1, 30'd0},
		'{ROW_LENGTH, 11'd3,    1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd97,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd98,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd99,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd100,  1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd0,    1'b0, 1'b0, 30'd0},
		// A start flag in the middle of a string restarts the fill.
		'{ROW_BYTE,   11'd255,  1'b1, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd1,    1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd200,  1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd95,   1'b0, 1'b0, 30'd0},
		'{ROW_LENGTH, 11'd2,    1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd10,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd20,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd30,   1'b0, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd40,   1'b1, 1'b0, 30'd0},
		'{ROW_BYTE,   11'd50,   1'b0, 1'b0, 30'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  symbol_byte;
	logic        start_of_string;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [29:0] hash_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] window_length;

	rolling_window_polynomial_hash #(
		.MAX_WINDOW(WINDOW_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol_byte(symbol_byte),
		.start_of_string(start_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hash_value(hash_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.window_length(window_length)
	);

	always #2 clk = ~clk;

	// While calm is set neither side idles.
	bit calm;
	int mismatches = 0;
	int bytes_sent;
	int hashes_checked = 0;
	int length_writes;
	int quiet_cycles = 0;

	// Hashes that the block still owes, oldest first.
	logic [29:0] owed_hashes [$];

	// Shadow copy of the block's state, kept by the hash predictor.
	logic [7:0]      seen_bytes [WINDOW_DEPTH];
	int unsigned     seen_pos;
	int unsigned     seen_fill;
	longint unsigned cur_hash;
	longint unsigned cur_power;
	logic [10:0]     cur_length;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_REPORTS) begin
			$display("MISMATCH at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic longint unsigned digit_value(input logic [7:0] b);
		longint unsigned p;
		longint unsigned off;
		p = longint'(HASH_PRIME);
		off = longint'(DIGIT_OFFSET);
		if (longint'(b) >= off) begin
			return longint'(b) - off;
		end
		return p - (off - longint'(b));
	endfunction

	function automatic int unsigned span_of(input logic [10:0] len);
		if (len == 11'd0) begin
			return 1;
		end
		if (len > 11'(WINDOW_DEPTH)) begin
			return WINDOW_DEPTH;
		end
		return len;
	endfunction

	function automatic void clear_string();
		seen_pos = 0;
		seen_fill = 0;
		cur_hash = 0;
		cur_power = 1;
	endfunction

	// Advances the shadow state by one byte beat. Returns 1 and the new hash
	// when the beat completes a full window.
	function automatic bit predict_window_hash(input logic [7:0] b, input logic sof,
			output logic [29:0] hash_out);
		longint unsigned p;
		longint unsigned base;
		longint unsigned d;
		longint unsigned drop;
		longint unsigned left;
		int unsigned m;
		bit full;
		p = longint'(HASH_PRIME);
		base = longint'(HASH_BASE);
		m = span_of(cur_length);
		d = digit_value(b);
		full = 1'b0;
		if (sof) begin
			clear_string();
		end
		if (seen_fill < m) begin
			if (seen_fill > 0) begin
				cur_power = (cur_power * base) % p;
			end
			cur_hash = ((cur_hash * base) % p + d) % p;
			seen_fill++;
			full = (seen_fill == m);
		end else begin
			// Take the oldest symbol out at its weight, then shift in the new one.
			drop = (digit_value(seen_bytes[(seen_pos + WINDOW_DEPTH - m) % WINDOW_DEPTH])
					* cur_power) % p;
			left = (cur_hash >= drop) ? cur_hash - drop : cur_hash + (p - drop);
			cur_hash = ((left * base) % p + d) % p;
			full = 1'b1;
		end
		seen_bytes[seen_pos % WINDOW_DEPTH] = b;
		seen_pos = (seen_pos + 1) % WINDOW_DEPTH;
		hash_out = cur_hash[29:0];
		return full;
	endfunction

	// Every task below is entered and left at a falling edge, so inputs only
	// ever change half a cycle away from the sampling edge.
	task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
			input logic [29:0] typed_hash);
		logic [29:0] h;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		in_valid = 1'b1;
		symbol_byte = b;
		start_of_string = sof;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (predict_window_hash(b, sof, h)) begin
			owed_hashes = {owed_hashes, (typed ? typed_hash : h)};
		end
		bytes_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits for every owed hash, then for the bytes that cause none to drain.
	task automatic settle();
		while (owed_hashes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_length(input logic [10:0] len);
		settle();
		cfg_valid = 1'b1;
		window_length = len;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cur_length = len;
		clear_string();
		length_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly lowercase text, which is what the hash is meant for, with raw
	// bytes of the full range and occasional start flags mixed in.
	task automatic stream_text(input int beats, input int sof_pct);
		logic [7:0] b;
		logic sof;
		for (int i = 0; i < beats; i++) begin
			b = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(97, 122))
					: 8'($urandom_range(0, 255));
			sof = ($urandom_range(0, 99) < sof_pct);
			send_byte(b, sof, 1'b0, 30'd0);
		end
	endtask

	// Receiver side: stalls at random except in the quiet stretch.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Each hash beat is compared with the oldest owed hash.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_hashes.size() == 0) begin
				flag_mismatch("hash beat with none owed", hash_value, -1);
			end else begin
				if (hash_value !== owed_hashes[0]) begin
					flag_mismatch("hash_value", hash_value, owed_hashes[0]);
				end
				void'(owed_hashes.pop_front());
			end
			hashes_checked++;
		end
	end

	// The run is stuck once no channel has moved a beat for a long while.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("rolling_window_polynomial_hash test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int random_beats;
		int span;
		int r;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol_byte = 8'd0;
		start_of_string = 1'b0;
		cfg_valid = 1'b0;
		window_length = 11'd1;
		calm = 1'b0;
		bytes_sent = 0;
		length_writes = 0;
		random_beats = 0;
		cur_length = 11'd1;
		clear_string();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_LENGTH) begin
				write_length(DIRECTED[i].value);
			end else begin
				send_byte(DIRECTED[i].value[7:0], DIRECTED[i].sof, DIRECTED[i].typed,
						DIRECTED[i].hash);
			end
		end

		// The largest window through a clamped length with every bit set: the
		// full fill, then a run of slides against the deepest power.
		write_length(11'd2047);
		stream_text(WINDOW_DEPTH + 40, 0);
		// The exact maximum must not give a hash before its window is full.
		write_length(11'(WINDOW_DEPTH));
		stream_text(30, 0);

		// Random phases, mostly short windows so that slides dominate.
		while (random_beats < RANDOM_BEATS) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				span = 0;
			end else if (r < 11) begin
				span = $urandom_range(WINDOW_DEPTH + 1, 2047);
			end else if (r < 20) begin
				span = 1;
			end else begin
				span = $urandom_range(2, 24);
			end
			write_length(11'(span));
			r = (span > WINDOW_DEPTH) ? $urandom_range(5, 15) : $urandom_range(20, 80);
			calm = (random_beats >= 50 && random_beats < 150);
			stream_text(r, 4);
			random_beats += r;
		end
		calm = 1'b0;

		// Drain, then leave time for any hash that should not come.
		while (owed_hashes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d byte beats over %0d length writes, lengths 0 to 2047 included;",
				bytes_sent, length_writes);
		$display("checked %0d hash beats, %0d mismatches.", hashes_checked, mismatches);
		if (mismatches == 0 && owed_hashes.size() == 0) begin
			$display("rolling_window_polynomial_hash test passed");
		end else begin
			$display("rolling_window_polynomial_hash test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rwph_pkg.sv
hw/rtl/rwph_front.sv
hw/rtl/rwph_queue.sv
hw/rtl/rwph_modmul.sv
hw/rtl/rwph_back.sv
hw/rtl/rolling_window_polynomial_hash.sv
tb/tb_rolling_window_polynomial_hash.sv
